FILE: src/bhq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared widths, capacity and status codes of the binary max-heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int unsigned KEY_W    = 8;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned DEPTH    = 1 << ADDR_W;
  localparam int unsigned CAPACITY = 127;

  localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

endpackage
`default_nettype wire

FILE: src/binary_max_heap_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit
// Max-heap priority queue of signed 8-bit keys held in an on-chip memory.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. An insert climbs the new key one
// level at a time until it reaches the root or stops below it; a remove moves
// the last key to the root and sinks it one level at a time until it reaches a
// leaf or stops above one. A rejected insert or a remove from an empty heap
// goes straight to the result. A full heap holds 127 keys. Each level is worked
// by a read, compare and write-back loop over the heap memory (two read ports,
// one write port, read data registered). Results wait in an output register; a
// new transaction is taken as soon as the previous result has moved into it. No
// clearing pass is needed after reset: only keys in slots up to the key count
// are ever used.
module binary_max_heap_queue_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_command,
  input  wire  signed [bhq_pkg::KEY_W-1:0] in_key_in,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [bhq_pkg::KEY_W-1:0] out_key_out,
  output logic [1:0]                   out_status,
  output logic [bhq_pkg::CNT_W-1:0]    out_fill_count
);
  import bhq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  // heap memory, slot 0 unused
  key_t heap_mem [DEPTH];

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  key_t              key_r, key_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  key_t              res_key_r, res_key_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  key_t              out_key_r, out_key_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  key_t              rd_a_r, rd_b_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  key_t              wr_data;

  logic              in_fire;
  logic [ADDR_W:0]   left_idx, right_idx, count_ext;
  logic              left_ok, right_ok, take_right;
  key_t              child_val;
  logic [ADDR_W-1:0] child_pos;

  assign in_ready       = (state_r == S_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_key_out    = out_key_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_count_r;

  assign left_idx   = {pos_r, 1'b0};
  assign right_idx  = {pos_r, 1'b1};
  assign count_ext  = {1'b0, count_r};
  assign left_ok    = (left_idx <= count_ext);
  assign right_ok   = (right_idx <= count_ext);
  // ties go to the left child
  assign take_right = right_ok && (rd_b_r > rd_a_r);
  assign child_val  = take_right ? rd_b_r : rd_a_r;
  assign child_pos  = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    res_key_nxt    = res_key_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr_a      = left_idx[ADDR_W-1:0];
    rd_addr_b      = right_idx[ADDR_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = key_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_key_nxt = '0;
          if (command_t'(in_command) == CMD_INSERT) begin
            if (count_r >= CAPACITY_CNT) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_FIN;
            end else begin
              res_status_nxt = ST_INSERTED;
              key_nxt        = in_key_in;
              pos_nxt        = ADDR_W'(count_r + 1'b1);
              count_nxt      = count_r + 1'b1;
              state_nxt      = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              // fetch root and last key together
              res_status_nxt = ST_REMOVED;
              rd_en          = 1'b1;
              rd_addr_a      = ADDR_W'(1);
              rd_addr_b      = ADDR_W'(count_r);
              count_nxt      = count_r - 1'b1;
              state_nxt      = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == ADDR_W'(1)) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = pos_r >> 1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (key_r > rd_a_r) begin
          wr_data   = rd_a_r;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_LOAD: begin
        res_key_nxt = rd_a_r;
        key_nxt     = rd_b_r;
        pos_nxt     = ADDR_W'(1);
        state_nxt   = S_DN_RD;
      end
      S_DN_RD: begin
        if (left_ok) begin
          rd_en     = 1'b1;
          state_nxt = S_DN_CMP;
        end else begin
          // no left child: write the key back, unless the heap became empty when the only key was removed
          wr_en     = (count_r != '0);
          state_nxt = S_FIN;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (key_r >= child_val) begin
          state_nxt = S_FIN;
        end else begin
          wr_data   = child_val;
          pos_nxt   = child_pos;
          state_nxt = S_DN_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = res_key_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    res_key_r    <= res_key_nxt;
    res_status_r <= res_status_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= heap_mem[rd_addr_a];
      rd_b_r <= heap_mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire
